// ----- rtl/core/lvm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_pkg
// Widths, types and helpers shared by the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lvm_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // the largest fitted magnitude of a nonzero vector lies in [2^(MW-1), 2^MW)
  localparam int MW   = 30;
  localparam int FUW  = MW + 1;
  localparam int UW   = FRAC_BITS + 2;
  localparam int PW   = FUW + UW;
  localparam int VW   = (COORD_WIDTH + 1 > PW + 1) ? COORD_WIDTH + 1 : PW + 1;
  localparam int SAW  = $clog2(VW);
  localparam int SQW  = 2 * MW;
  localparam int SW   = SQW + 2;
  localparam int NIT  = SW / 2;
  localparam int RW   = MW + 1;
  localparam int QB   = FRAC_BITS + 1;
  localparam int DVW  = MW + FRAC_BITS + 1;
  localparam int TPW  = UW + COORD_WIDTH;
  localparam int TW   = TPW + 2;
  localparam int TSW  = TW - FRAC_BITS;
  localparam int TRW  = TSW + 1;

  localparam logic [QB-1:0]          ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [COORD_WIDTH-1:0] ONE_C = COORD_WIDTH'(ONE_Q);
  localparam logic [TW-1:0]          HALF_T = TW'(1) << (FRAC_BITS - 1);
  localparam logic signed [TRW-1:0]  MAX_T =
    {{(TRW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [TRW-1:0]  MIN_T =
    {{(TRW - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};
  localparam logic [COORD_WIDTH-1:0] MAX_C = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] MIN_C = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

  typedef logic signed [COORD_WIDTH-1:0] crd_t;
  typedef crd_t [2:0]                    crd3_t;
  typedef logic signed [UW-1:0]          unt_t;
  typedef unt_t [2:0]                    unt3_t;
  typedef logic signed [FUW-1:0]         fup_t;
  typedef fup_t [2:0]                    fup3_t;
  typedef logic signed [VW-1:0]          vec_t;
  typedef vec_t [2:0]                    vec3_t;

  typedef struct packed {
    logic  ident;
    logic  okn;
    logic  oku;
    crd3_t eye;
    crd3_t up;
    fup3_t upf;
    unt3_t n;
    unt3_t u;
  } side_t;

  typedef struct packed {
    crd_t eye_x;
    crd_t eye_y;
    crd_t eye_z;
    crd_t target_x;
    crd_t target_y;
    crd_t target_z;
    crd_t upward_x;
    crd_t upward_y;
    crd_t upward_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0] row_index;
    crd_t       col0;
    crd_t       col1;
    crd_t       col2;
    crd_t       col3;
    logic       last_row;
    logic       degenerate;
  } out_item_t;

  typedef out_item_t [3:0] mat_t;

  function automatic logic [VW-1:0] abs_v(input logic [VW-1:0] x);
    return x[VW-1] ? (~x + VW'(1)) : x;
  endfunction

  function automatic logic [SAW-1:0] msb_pos(input logic [VW-1:0] x);
    logic [SAW-1:0] p;
    p = '0;
    for (int i = 0; i < VW; i++) begin
      if (x[i]) p = SAW'(i);
    end
    return p;
  endfunction

endpackage

// ----- rtl/core/lvm_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_in_if / lvm_out_if
// Valid/ready channels carrying one input item or one matrix row.
// ----------------------------------------------------------------------------
interface lvm_in_if;
  import lvm_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lvm_out_if;
  import lvm_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/lvm_norm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_norm
// Pipelined normalize: block fit, sum of squares, bit-per-stage square root,
// bit-per-stage division of the three lanes, sign and clamp.
// Also fits the side up vector alongside.
// ----------------------------------------------------------------------------
module lvm_norm (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  lvm_pkg::vec3_t  in_vec,
  input  lvm_pkg::side_t  in_side,
  output logic            out_vld,
  output lvm_pkg::unt3_t  out_unit,
  output logic            out_ok,
  output lvm_pkg::side_t  out_side
);
  import lvm_pkg::*;

  localparam int LAT = 5 + NIT + 1 + QB + 1;

  typedef struct packed {
    logic [2:0][MW-1:0] fm;
    logic [2:0]         neg;
    logic               nz;
    side_t              side;
  } nc_t;

  logic [LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_vld};
    end
  end

  assign out_vld = vld_r[LAT-1];

  // magnitudes
  logic [2:0][VW-1:0] mag1_r, umag1_r;
  logic [2:0]         neg1_r, uneg1_r;
  side_t              side1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        mag1_r[j]  <= abs_v(in_vec[j]);
        neg1_r[j]  <= in_vec[j][VW-1];
        umag1_r[j] <= abs_v(VW'($signed(in_side.up[j])));
        uneg1_r[j] <= in_side.up[j][COORD_WIDTH-1];
      end
      side1_r <= in_side;
    end
  end

  // shift amount from the leading one of the largest magnitude
  logic [VW-1:0]  or_v, or_u;
  logic [SAW-1:0] p_v, p_u;
  logic           rsh_v, rsh_u;
  logic [SAW-1:0] amt_v, amt_u;

  always_comb begin
    or_v  = mag1_r[0] | mag1_r[1] | mag1_r[2];
    or_u  = umag1_r[0] | umag1_r[1] | umag1_r[2];
    p_v   = msb_pos(or_v);
    p_u   = msb_pos(or_u);
    rsh_v = p_v > SAW'(MW - 1);
    rsh_u = p_u > SAW'(MW - 1);
    amt_v = rsh_v ? p_v - SAW'(MW - 1) : SAW'(MW - 1) - p_v;
    amt_u = rsh_u ? p_u - SAW'(MW - 1) : SAW'(MW - 1) - p_u;
  end

  logic [2:0][VW-1:0] mag2_r, umag2_r;
  logic [2:0]         neg2_r, uneg2_r;
  logic               nz2_r, rsh2_r, ursh2_r;
  logic [SAW-1:0]     amt2_r, uamt2_r;
  side_t              side2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mag2_r  <= mag1_r;
      umag2_r <= umag1_r;
      neg2_r  <= neg1_r;
      uneg2_r <= uneg1_r;
      nz2_r   <= |or_v;
      rsh2_r  <= rsh_v;
      ursh2_r <= rsh_u;
      amt2_r  <= amt_v;
      uamt2_r <= amt_u;
      side2_r <= side1_r;
    end
  end

  // apply the shift
  nc_t c3;
  logic [VW-1:0] sv, su;
  logic [FUW-1:0] ue;

  always_comb begin
    c3      = '0;
    c3.neg  = neg2_r;
    c3.nz   = nz2_r;
    c3.side = side2_r;
    sv      = '0;
    su      = '0;
    ue      = '0;
    for (int j = 0; j < 3; j++) begin
      sv = rsh2_r ? (mag2_r[j] >> amt2_r) : (mag2_r[j] << amt2_r);
      su = ursh2_r ? (umag2_r[j] >> uamt2_r) : (umag2_r[j] << uamt2_r);
      c3.fm[j] = sv[MW-1:0];
      ue = {1'b0, su[MW-1:0]};
      c3.side.upf[j] = uneg2_r[j] ? (~ue + FUW'(1)) : ue;
    end
  end

  nc_t c3_r, c4_r;
  logic [2:0][SQW-1:0] sq4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c3_r <= c3;
      for (int j = 0; j < 3; j++) begin
        sq4_r[j] <= SQW'(c3_r.fm[j]) * SQW'(c3_r.fm[j]);
      end
      c4_r <= c3_r;
    end
  end

  // square root, one result bit per stage
  logic [SW-1:0] sn_r [NIT+1];
  logic [SW-1:0] sr_r [NIT+1];
  nc_t           sc_r [NIT+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sn_r[0] <= SW'(sq4_r[0]) + SW'(sq4_r[1]) + SW'(sq4_r[2]);
      sr_r[0] <= '0;
      sc_r[0] <= c4_r;
    end
  end

  for (genvar i = 0; i < NIT; i++) begin : g_sqrt
    localparam int SH = 2 * (NIT - 1 - i);
    logic [SW-1:0] bitv, trial;
    logic          ge;

    always_comb begin
      bitv  = SW'(1) << SH;
      trial = sr_r[i] + bitv;
      ge    = sn_r[i] >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sn_r[i+1] <= ge ? sn_r[i] - trial : sn_r[i];
        sr_r[i+1] <= ge ? (sr_r[i] >> 1) + bitv : sr_r[i] >> 1;
        sc_r[i+1] <= sc_r[i];
      end
    end
  end

  // rounded division of each lane by the root
  logic [2:0][DVW-1:0] dv_r [QB+1];
  logic [2:0][RW-1:0]  rm_r [QB+1];
  logic [2:0][QB-1:0]  q_r  [QB+1];
  logic [RW-1:0]       dr_r [QB+1];
  nc_t                 dc_r [QB+1];

  logic [RW-1:0]       root;
  logic [2:0][DVW-1:0] dvd;

  always_comb begin
    root = sr_r[NIT][RW-1:0];
    for (int j = 0; j < 3; j++) begin
      dvd[j] = {1'b0, sc_r[NIT].fm[j], {FRAC_BITS{1'b0}}} + DVW'(root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        dv_r[0][j] <= dvd[j];
        rm_r[0][j] <= RW'(dvd[j] >> QB);
      end
      q_r[0]  <= '0;
      dr_r[0] <= root;
      dc_r[0] <= sc_r[NIT];
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int BI = QB - 1 - k;
    logic [2:0][RW:0]   r2;
    logic [2:0]         ge;
    logic [2:0][QB-1:0] qn;

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        r2[j]     = {rm_r[k][j], dv_r[k][j][BI]};
        ge[j]     = r2[j] >= {1'b0, dr_r[k]};
        qn[j]     = q_r[k][j];
        qn[j][BI] = ge[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int j = 0; j < 3; j++) begin
          rm_r[k+1][j] <= ge[j] ? RW'(r2[j] - {1'b0, dr_r[k]}) : r2[j][RW-1:0];
        end
        q_r[k+1]  <= qn;
        dv_r[k+1] <= dv_r[k];
        dr_r[k+1] <= dr_r[k];
        dc_r[k+1] <= dc_r[k];
      end
    end
  end

  // sign, clamp, zero vector
  unt3_t          unit;
  logic [QB-1:0]  qc;
  logic [UW-1:0]  uq;

  always_comb begin
    unit = '0;
    qc   = '0;
    uq   = '0;
    for (int j = 0; j < 3; j++) begin
      qc = (q_r[QB][j] > ONE_Q) ? ONE_Q : q_r[QB][j];
      uq = {1'b0, qc};
      if (dc_r[QB].nz) begin
        unit[j] = dc_r[QB].neg[j] ? (~uq + UW'(1)) : uq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_unit <= unit;
      out_ok   <= dc_r[QB].nz;
      out_side <= dc_r[QB].side;
    end
  end

endmodule

// ----- rtl/core/lvm_cross.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_cross
// Two-stage exact cross product a x b: six products, then differences.
// ----------------------------------------------------------------------------
module lvm_cross (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  lvm_pkg::fup3_t  a,
  input  lvm_pkg::unt3_t  b,
  input  lvm_pkg::side_t  in_side,
  output logic            out_vld,
  output lvm_pkg::vec3_t  out_vec,
  output lvm_pkg::side_t  out_side
);
  import lvm_pkg::*;

  logic [1:0]         vld_r;
  logic [5:0][PW-1:0] p_r;
  side_t              side1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0]  <= $signed(a[1]) * $signed(b[2]);
      p_r[1]  <= $signed(a[2]) * $signed(b[1]);
      p_r[2]  <= $signed(a[2]) * $signed(b[0]);
      p_r[3]  <= $signed(a[0]) * $signed(b[2]);
      p_r[4]  <= $signed(a[0]) * $signed(b[1]);
      p_r[5]  <= $signed(a[1]) * $signed(b[0]);
      side1_r <= in_side;
      out_vec[0] <= VW'($signed(p_r[0])) - VW'($signed(p_r[1]));
      out_vec[1] <= VW'($signed(p_r[2])) - VW'($signed(p_r[3]));
      out_vec[2] <= VW'($signed(p_r[4])) - VW'($signed(p_r[5]));
      out_side   <= side1_r;
    end
  end

  assign out_vld = vld_r[1];

endmodule

// ----- rtl/core/lvm_xlat.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_xlat
// Translation column and row assembly: products with eye, rounded sum,
// negate and saturate, then degenerate and eye-equals-target overrides.
// ----------------------------------------------------------------------------
module lvm_xlat (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  lvm_pkg::unt3_t  v,
  input  logic            okv,
  input  lvm_pkg::side_t  in_side,
  output logic            out_vld,
  output lvm_pkg::mat_t   out_mat
);
  import lvm_pkg::*;

  logic [2:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  assign out_vld = vld_r[2];

  unt3_t [2:0] rows;
  logic  [2:0] oks;

  always_comb begin
    rows[0] = in_side.u;
    rows[1] = v;
    rows[2] = in_side.n;
    oks     = {in_side.okn, okv, in_side.oku};
  end

  logic [2:0][2:0][TPW-1:0] pr1_r;
  unt3_t [2:0]              rows1_r, rows2_r;
  logic  [2:0]              ok1_r, ok2_r;
  logic                     id1_r, id2_r;
  logic [2:0][TSW-1:0]      rs2_r;
  logic [2:0][TW-1:0]       acc;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = TW'($signed(pr1_r[k][0])) + TW'($signed(pr1_r[k][1]))
             + TW'($signed(pr1_r[k][2])) + HALF_T;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) begin
          pr1_r[k][i] <= $signed(rows[k][i]) * $signed(in_side.eye[i]);
        end
        rs2_r[k] <= acc[k][TW-1:FRAC_BITS];
      end
      rows1_r <= rows;
      ok1_r   <= oks;
      id1_r   <= in_side.ident;
      rows2_r <= rows1_r;
      ok2_r   <= ok1_r;
      id2_r   <= id1_r;
    end
  end

  logic signed [TRW-1:0]     ng;
  logic [2:0][COORD_WIDTH-1:0] tr;
  mat_t                      m;

  always_comb begin
    ng = '0;
    for (int k = 0; k < 3; k++) begin
      ng = TRW'(0) - TRW'($signed(rs2_r[k]));
      if (ng > MAX_T) begin
        tr[k] = MAX_C;
      end else if (ng < MIN_T) begin
        tr[k] = MIN_C;
      end else begin
        tr[k] = ng[COORD_WIDTH-1:0];
      end
    end
    m = '0;
    for (int k = 0; k < 4; k++) begin
      m[k].row_index = 2'(k);
    end
    if (id2_r) begin
      m[0].col0 = ONE_C;
      m[1].col1 = ONE_C;
      m[2].col2 = ONE_C;
    end else begin
      for (int k = 0; k < 3; k++) begin
        m[k].degenerate = !ok2_r[k];
        if (ok2_r[k]) begin
          m[k].col0 = COORD_WIDTH'($signed(rows2_r[k][0]));
          m[k].col1 = COORD_WIDTH'($signed(rows2_r[k][1]));
          m[k].col2 = COORD_WIDTH'($signed(rows2_r[k][2]));
          m[k].col3 = tr[k];
        end
      end
    end
    m[3].col3     = ONE_C;
    m[3].last_row = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_mat <= m;
    end
  end

endmodule

// ----- rtl/core/lookat_view_matrix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lookat_view_matrix
// Look-at view matrix from eye, target and up (signed Q16.16), sent as four
// rows: u, v and n with their translation entries, then 0,0,0,1.
//
//   channel  dir  payload                         transfer
//   in_ch    in   eye, target, upward (x,y,z)     one item per matrix
//   out_ch   out  row_index, col0..col3, flags    four items per matrix
//
// One item enters per cycle, unless the row port stalls, into a 173-stage
// pipeline (three normalize units of 55 stages each: 31 square-root and 17
// divide stages). The single row port, four rows per matrix, sets the rate.
// Reset is synchronous, active low, and clears only valid and row state.
// A stall at the row port holds the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module lookat_view_matrix (
  input  logic             clk,
  input  logic             rst_n,
  lvm_in_if.sink           in_ch,
  lvm_out_if.source        out_ch
);
  import lvm_pkg::*;

  logic adv;
  logic take;

  // entry stage: difference and eye-equals-target test
  logic  vld0_r;
  vec3_t vec0_r;
  side_t side0_r;
  side_t side0;
  vec3_t vec0;

  always_comb begin
    side0        = '0;
    side0.eye[0] = in_ch.payload.eye_x;
    side0.eye[1] = in_ch.payload.eye_y;
    side0.eye[2] = in_ch.payload.eye_z;
    side0.up[0]  = in_ch.payload.upward_x;
    side0.up[1]  = in_ch.payload.upward_y;
    side0.up[2]  = in_ch.payload.upward_z;
    side0.ident  = (in_ch.payload.eye_x == in_ch.payload.target_x)
                && (in_ch.payload.eye_y == in_ch.payload.target_y)
                && (in_ch.payload.eye_z == in_ch.payload.target_z);
    vec0[0] = VW'($signed(in_ch.payload.eye_x)) - VW'($signed(in_ch.payload.target_x));
    vec0[1] = VW'($signed(in_ch.payload.eye_y)) - VW'($signed(in_ch.payload.target_y));
    vec0[2] = VW'($signed(in_ch.payload.eye_z)) - VW'($signed(in_ch.payload.target_z));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (adv) begin
      vld0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vec0_r  <= vec0;
      side0_r <= side0;
    end
  end

  assign in_ch.ready = adv;

  // n
  logic  n1_vld, n1_ok;
  unt3_t n1_unit;
  side_t n1_side, x1_side_in;

  lvm_norm u_norm_n (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (vld0_r),
    .in_vec   (vec0_r),
    .in_side  (side0_r),
    .out_vld  (n1_vld),
    .out_unit (n1_unit),
    .out_ok   (n1_ok),
    .out_side (n1_side)
  );

  always_comb begin
    x1_side_in     = n1_side;
    x1_side_in.n   = n1_unit;
    x1_side_in.okn = n1_ok;
  end

  // up x n
  logic  x1_vld;
  vec3_t x1_vec;
  side_t x1_side;

  lvm_cross u_cross_u (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (n1_vld),
    .a        (n1_side.upf),
    .b        (n1_unit),
    .in_side  (x1_side_in),
    .out_vld  (x1_vld),
    .out_vec  (x1_vec),
    .out_side (x1_side)
  );

  // u
  logic  n2_vld, n2_ok;
  unt3_t n2_unit;
  side_t n2_side, x2_side_in;
  fup3_t n_ext;

  lvm_norm u_norm_u (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (x1_vld),
    .in_vec   (x1_vec),
    .in_side  (x1_side),
    .out_vld  (n2_vld),
    .out_unit (n2_unit),
    .out_ok   (n2_ok),
    .out_side (n2_side)
  );

  always_comb begin
    x2_side_in     = n2_side;
    x2_side_in.u   = n2_unit;
    x2_side_in.oku = n2_ok;
    for (int j = 0; j < 3; j++) begin
      n_ext[j] = FUW'($signed(n2_side.n[j]));
    end
  end

  // n x u
  logic  x2_vld;
  vec3_t x2_vec;
  side_t x2_side;

  lvm_cross u_cross_v (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (n2_vld),
    .a        (n_ext),
    .b        (n2_unit),
    .in_side  (x2_side_in),
    .out_vld  (x2_vld),
    .out_vec  (x2_vec),
    .out_side (x2_side)
  );

  // v
  logic  n3_vld, n3_ok;
  unt3_t n3_unit;
  side_t n3_side;

  lvm_norm u_norm_v (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (x2_vld),
    .in_vec   (x2_vec),
    .in_side  (x2_side),
    .out_vld  (n3_vld),
    .out_unit (n3_unit),
    .out_ok   (n3_ok),
    .out_side (n3_side)
  );

  // translation and row assembly
  logic xl_vld;
  mat_t xl_mat;

  lvm_xlat u_xlat (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (n3_vld),
    .v        (n3_unit),
    .okv      (n3_ok),
    .in_side  (n3_side),
    .out_vld  (xl_vld),
    .out_mat  (xl_mat)
  );

  // row output register
  logic       busy_r;
  logic [1:0] cnt_r;
  mat_t       mat_r;
  logic       row_done;

  assign row_done = busy_r && out_ch.ready;
  assign take     = xl_vld && (!busy_r || (row_done && cnt_r == 2'd3));
  assign adv      = !xl_vld || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (take) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (row_done) begin
      busy_r <= cnt_r != 2'd3;
      cnt_r  <= cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mat_r <= xl_mat;
    end
  end

  assign out_ch.valid   = busy_r;
  assign out_ch.payload = mat_r[cnt_r];

endmodule

// ----- rtl/core/lvm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvm_checker
// Port-level checks on the row sequence and row contents of the view matrix output.
// ----------------------------------------------------------------------------
module lvm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input lvm_pkg::out_item_t  out_item
);
  import lvm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("row changed while stalled");

  a_next_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_item.last_row) |=>
      (out_valid && out_item.row_index == $past(out_item.row_index) + 2'd1))
    else $error("row sequence broken");

  a_first_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_item.last_row) |=>
      (!out_valid || out_item.row_index == 2'd0))
    else $error("matrix does not start at row 0");

  a_row3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_item.last_row == (out_item.row_index == 2'd3))
      && (!out_item.last_row || (out_item.col0 == '0 && out_item.col1 == '0
      && out_item.col2 == '0 && out_item.col3 == ONE_C && !out_item.degenerate))))
    else $error("bad final row");

  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.degenerate) |->
      (out_item.col0 == '0 && out_item.col1 == '0
       && out_item.col2 == '0 && out_item.col3 == '0))
    else $error("degenerate row not zero");

endmodule

bind lookat_view_matrix lvm_checker u_lvm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.payload)
);
